// File: hw/rtl/postfix_expression_evaluator_macros.svh
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PEE_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PEE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define PEE_ASSERT_IMPL(label, clk, rst, prop)
`define PEE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: hw/rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Types and constants shared by the postfix expression evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pee_pkg;
   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5,
      OP_END  = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
   } cmd_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_DIVZERO = 2'd3;

   localparam logic [7:0] CH_ADD  = 8'h2B;
   localparam logic [7:0] CH_SUB  = 8'h2D;
   localparam logic [7:0] CH_MUL  = 8'h2A;
   localparam logic [7:0] CH_DIV  = 8'h2F;
   localparam logic [7:0] CH_POW  = 8'h5E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Saturate a 49-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sh0_7FFF_FFFF) begin
         r = Q_MAX;
      end else if (v < -49'sh0_8000_0000) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front
// Classifies input items into commands and puts all but unknown ones in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_front import pee_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_is_end,
   output logic            cmd_valid,
   input  wire logic       cmd_take,
   output cmd_type         cmd_data
);
   cmd_type    q_ff [4];
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] wp_ff, rp_ff;
   cmd_type    cls;
   logic       push, pop;

   always_comb begin
      cls.digit = 4'(req_symbol - CH_ZERO);
      cls.op    = OP_NONE;
      if (req_is_end) begin
         cls.op = OP_END;
      end else if (req_symbol >= CH_ZERO && req_symbol <= CH_NINE) begin
         cls.op = OP_PUSH;
      end else begin
         case (req_symbol)
            CH_ADD:  cls.op = OP_ADD;
            CH_SUB:  cls.op = OP_SUB;
            CH_MUL:  cls.op = OP_MUL;
            CH_DIV:  cls.op = OP_DIV;
            CH_POW:  cls.op = OP_POW;
            default: cls.op = OP_NONE;
         endcase
      end
   end

   assign req_stall = (cnt_ff == 3'd4);
   assign push      = req_valid && !req_stall && cls.op != OP_NONE;
   assign cmd_valid = (cnt_ff != 3'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rp_ff];
   assign cnt_in    = cnt_ff + 3'(push) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= '0;
         rp_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_ff + 2'(push);
         rp_ff  <= rp_ff + 2'(pop);
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu
// Multi-cycle Q16.16 unit: add, subtract, multiply, divide and power.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_alu import pee_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  op_type                  op,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic                    done,
   output logic                    div_zero,
   output logic signed [31:0]      result
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL1  = 7'b0000010,
      S_MUL2  = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_DFIN  = 7'b0010000,
      S_PSTEP = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic signed [31:0] a_ff, r_ff, x_ff, y_ff;
   logic signed [63:0] prod_ff;
   logic [4:0]  bit_ff;
   logic        sq_ff, pneg_ff, dz_ff;
   logic [15:0] m_ff;
   logic [47:0] rem_ff, quo_ff;
   logic [5:0]  dcnt_ff;
   logic        qneg_ff;
   logic [31:0] dvs_ff;
   logic signed [63:0] prod;
   logic signed [48:0] fl;
   logic signed [31:0] mres, n;
   logic [48:0] trial;
   logic [47:0] dvd;
   logic signed [48:0] q49;

   assign prod  = 64'(x_ff) * 64'(y_ff);
   assign fl    = 49'(prod_ff >>> 16);
   assign mres  = sat49(fl);
   assign n     = b / 32'sd65536;
   assign trial = {rem_ff, quo_ff[47]} - {17'd0, dvs_ff};
   assign q49   = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign dvd   = {a[31] ? 32'(-a) : 32'(a), 16'd0};
   assign done     = (state_ff == S_DONE);
   assign div_zero = dz_ff;
   assign result   = r_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) begin
            case (op)
               OP_ADD, OP_SUB: state_in = S_DONE;
               OP_MUL:         state_in = S_MUL1;
               OP_DIV:         state_in = (b == 0) ? S_DONE : S_DIV;
               default:        state_in = S_MUL1;
            endcase
         end
         S_MUL1:  state_in = S_MUL2;
         S_MUL2: begin
            if (op_ff == OP_MUL) begin
               state_in = S_DONE;
            end else if (sq_ff || m_ff[bit_ff[3:0]]) begin
               state_in = S_PSTEP;
            end else begin
               state_in = S_PSTEP;
            end
         end
         S_PSTEP: state_in = S_MUL1;
         S_DIV:   state_in = (dcnt_ff == 6'd47) ? S_DFIN : S_DIV;
         S_DFIN:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (start) begin
            op_ff <= op;
            a_ff  <= a;
            dz_ff <= 1'b0;
            case (op)
               OP_ADD:  r_ff <= sat49(49'(a) + 49'(b));
               OP_SUB:  r_ff <= sat49(49'(a) - 49'(b));
               OP_MUL: begin
                  x_ff <= a;
                  y_ff <= b;
               end
               OP_DIV: begin
                  dz_ff   <= (b == 0);
                  qneg_ff <= a[31] ^ b[31];
                  dvs_ff  <= b[31] ? 32'(-b) : 32'(b);
                  rem_ff  <= '0;
                  quo_ff  <= dvd;
                  dcnt_ff <= '0;
               end
               default: begin
                  pneg_ff <= n[31];
                  m_ff    <= n[31] ? 16'(-n) : 16'(n);
                  r_ff    <= Q_ONE;
                  x_ff    <= Q_ONE;
                  y_ff    <= Q_ONE;
                  bit_ff  <= 5'd15;
                  sq_ff   <= 1'b1;
               end
            endcase
         end
         S_MUL1: prod_ff <= prod;
         S_MUL2: begin
            if (op_ff == OP_MUL) begin
               r_ff <= mres;
            end else begin
               r_ff <= mres;
            end
         end
         S_PSTEP: begin
            // Power: squaring step, then optional multiply by the base.
            if (sq_ff && m_ff[bit_ff[3:0]]) begin
               sq_ff <= 1'b0;
               x_ff  <= r_ff;
               y_ff  <= a_ff;
            end else if (bit_ff != 5'd0) begin
               sq_ff  <= 1'b1;
               bit_ff <= bit_ff - 5'd1;
               x_ff   <= r_ff;
               y_ff   <= r_ff;
            end else begin
               bit_ff <= 5'd31;
            end
         end
         S_DIV: begin
            if (!trial[48]) begin
               rem_ff <= trial[47:0];
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[46:0], quo_ff[47]};
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 6'd1;
         end
         S_DFIN: r_ff <= sat49(q49);
         default: ;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
      end else if (state_ff == S_PSTEP && bit_ff == 5'd0 &&
                   !(sq_ff && m_ff[0])) begin
         if (pneg_ff) begin
            if (r_ff == 0) begin
               dz_ff    <= 1'b1;
               state_ff <= S_DONE;
            end else begin
               qneg_ff  <= r_ff[31];
               dvs_ff   <= r_ff[31] ? 32'(-r_ff) : 32'(r_ff);
               rem_ff   <= '0;
               quo_ff   <= {Q_ONE, 16'd0};
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
         end else begin
            state_ff <= S_DONE;
         end
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back
// Executes queued commands against the operand stack and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_back import pee_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_take,
   input  cmd_type            cmd_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_RD   = 4'b0010,
      B_EXEC = 4'b0100,
      B_WAIT = 4'b1000
   } bstate_type;

   bstate_type state_ff;
   logic signed [31:0] mem [STACK_DEPTH];
   logic signed [31:0] top_ff, sec_ff;
   logic [CW-1:0] cnt_ff;
   logic [1:0]    err_ff;
   op_type        op_ff;
   logic          out_v_ff;
   logic signed [31:0] out_val_ff;
   logic [1:0]    out_st_ff;
   logic          alu_start, alu_done, alu_dz;
   logic signed [31:0] alu_res;
   logic [AW-1:0] rd_top, rd_sec, wr_a;
   logic          wr_en;
   logic signed [31:0] wr_d;
   logic          accept;

   pee_alu u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(op_ff),
      .a(sec_ff), .b(top_ff), .done(alu_done), .div_zero(alu_dz), .result(alu_res)
   );

   assign rsp_valid  = out_v_ff;
   assign rsp_value  = out_val_ff;
   assign rsp_status = out_st_ff;
   assign accept     = (state_ff == B_IDLE) && cmd_valid &&
                       !(cmd_data.op == OP_END && out_v_ff && rsp_stall);
   assign cmd_take   = accept;
   assign rd_top     = AW'(cnt_ff - CW'(1));
   assign rd_sec     = AW'(cnt_ff - CW'(2));
   assign alu_start  = (state_ff == B_EXEC);

   always_comb begin
      wr_en = 1'b0;
      wr_a  = rd_sec;
      wr_d  = alu_res;
      if (accept && cmd_data.op == OP_PUSH && err_ff == ST_OK &&
          cnt_ff < CW'(STACK_DEPTH)) begin
         wr_en = 1'b1;
         wr_a  = AW'(cnt_ff);
         wr_d  = {12'd0, cmd_data.digit, 16'd0};
      end else if (state_ff == B_WAIT && alu_done && !alu_dz) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_a] <= wr_d;
      end
      if (state_ff == B_RD) begin
         top_ff <= mem[rd_top];
         sec_ff <= mem[rd_sec];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cmd_data.op == OP_END) begin
         out_val_ff <= (err_ff == ST_OK && cnt_ff != '0) ? mem[rd_top] : '0;
         out_st_ff  <= (err_ff != ST_OK) ? err_ff :
                       ((cnt_ff == '0) ? ST_EMPTY : ST_OK);
      end
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         err_ff   <= ST_OK;
         out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: if (accept) begin
               op_ff <= cmd_data.op;
               case (cmd_data.op)
                  OP_END: begin
                     out_v_ff <= 1'b1;
                     cnt_ff   <= '0;
                     err_ff   <= ST_OK;
                  end
                  OP_PUSH: if (err_ff == ST_OK) begin
                     if (cnt_ff < CW'(STACK_DEPTH)) begin
                        cnt_ff <= cnt_ff + CW'(1);
                     end else begin
                        err_ff <= ST_FULL;
                     end
                  end
                  OP_NONE: ;
                  default: if (err_ff == ST_OK) begin
                     if (cnt_ff < CW'(2)) begin
                        err_ff <= ST_EMPTY;
                     end else begin
                        state_ff <= B_RD;
                     end
                  end
               endcase
            end
            B_RD:   state_ff <= B_EXEC;
            B_EXEC: state_ff <= B_WAIT;
            B_WAIT: if (alu_done) begin
               state_ff <= B_IDLE;
               if (alu_dz) begin
                  err_ff <= ST_DIVZERO;
               end else begin
                  cnt_ff <= cnt_ff - CW'(1);
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/postfix_expression_evaluator.sv
// An item is registered in a four-entry queue, so the back part can take it in the cycle after it is
// written at the earliest, and an end marker's result is registered and valid in the cycle after that.
// The back part handles a digit or end marker in its idle state; an operator passes through its read,
// execute and wait states while the ALU works. A power does 16 to 32 squarings or multiplies, and
// a negative exponent adds a reciprocal divide. The input stalls only when the queue is full.
// Synchronous active-high reset empties the queue, the stack and the error state.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix Q16.16 expressions one character item at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "postfix_expression_evaluator_macros.svh"
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_symbol,
   input  wire logic          req_is_end,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   pee_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_symbol(req_symbol), .req_is_end(req_is_end),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data)
   );

   pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd_data(cmd_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   `PEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value))
   `PEE_ASSERT_IMPL(a_take_valid, clock, reset, cmd_take |-> cmd_valid)
   `PEE_ASSERT_IMPL(a_err_value_zero, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_value == 0)
endmodule
`default_nettype wire
